FILE: design/bthq_pkg.sv
// ----------------------------------------------------------------------------
// Box terrain height query: shared package
// Field widths, operation and register codes, the stored box entry, and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package bthq_pkg;

   // Fixed widths of the payload fields (signed Q8.16 coordinates and heights)
   localparam int DATA_W      = 24;
   localparam int COUNT_W     = 7;
   localparam int INDEX_W     = 6;
   localparam int CSR_IDX_W   = 2;

   // Default table size
   localparam int MAX_BOXES_DEF = 64;

   // Operation codes of an input beat
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_X_LOWER   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_UPPER   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEF_HT    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_COUNT = 2'd3;

   // One table entry as held in the box RAM
   typedef struct packed {
      logic signed [DATA_W-1:0] corner_x;
      logic signed [DATA_W-1:0] corner_y;
      logic signed [DATA_W-1:0] extent_x;
      logic signed [DATA_W-1:0] extent_y;
      logic signed [DATA_W-1:0] top;
   } box_entry_type;

   localparam int ENTRY_W = $bits(box_entry_type);

   // Controller to datapath
   typedef struct packed {
      logic load;     // write the request's box into the table
      logic capture;  // latch the query point, seed the running maximum
      logic rd_en;    // read one table entry for the scan
      logic emit;     // present the result beat
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic               out_of_range; // request x outside the terrain limits
      logic               pipe_busy;    // scan reads still in flight
      logic [COUNT_W-1:0] box_count;    // configured number of boxes
   } dp_status_type;

endpackage

FILE: design/bthq_ram.sv
// ----------------------------------------------------------------------------
// Box terrain height query: generic RAM
// One write port and one read port, read data registered. No reset.
// ----------------------------------------------------------------------------
module bthq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/bthq_ctrl.sv
// ----------------------------------------------------------------------------
// Box terrain height query: controller
// Accepts request beats, steps the table scan address and tells the datapath
// when to load, capture, read and emit.
// ----------------------------------------------------------------------------
module bthq_ctrl #(
   parameter int MAX_BOXES = bthq_pkg::MAX_BOXES_DEF,
   localparam int ADDR_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    req_op,
   output logic                    busy,
   input  bthq_pkg::dp_status_type status,
   output bthq_pkg::ctrl_cmd_type  cmd,
   output logic [ADDR_W-1:0]       rd_addr
);
   import bthq_pkg::*;

   localparam int CNT_W = $clog2(MAX_BOXES + 1);
   localparam int CMP_W = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] num_ff, num_in;
   logic [CMP_W-1:0] count_ext;
   logic [CMP_W-1:0] count_clamp;
   logic [CNT_W-1:0] idx_next;
   logic             accept;

   assign accept      = start && (state_ff == ST_IDLE);
   assign count_ext   = CMP_W'(status.box_count);
   assign count_clamp = (count_ext > CMP_W'(MAX_BOXES)) ? CMP_W'(MAX_BOXES) : count_ext;
   assign idx_next    = idx_ff + 1'b1;

   // Next state and scan counter
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      num_in   = num_ff;
      cmd      = '0;
      cmd.load    = accept && (req_op == OP_LOAD);
      cmd.capture = accept && (req_op == OP_QUERY);
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               idx_in = '0;
               num_in = CNT_W'(count_clamp);
               // skip the scan when the point is off the terrain or no boxes
               if (status.out_of_range || (count_clamp == '0)) begin
                  state_in = ST_DRAIN;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.rd_en = 1'b1;
            idx_in    = idx_next;
            if (idx_next == num_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         num_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         num_ff   <= num_in;
      end
   end

   assign busy    = (state_ff != ST_IDLE);
   assign rd_addr = idx_ff[ADDR_W-1:0];

endmodule

FILE: design/bthq_dp.sv
// ----------------------------------------------------------------------------
// Box terrain height query: datapath
// Configuration registers, the box table, the containment test and the
// running maximum, and the result register.
// ----------------------------------------------------------------------------
module bthq_dp #(
   parameter int MAX_BOXES = bthq_pkg::MAX_BOXES_DEF,
   localparam int ADDR_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  bthq_pkg::ctrl_cmd_type                    cmd,
   output bthq_pkg::dp_status_type                   status,
   input  logic [ADDR_W-1:0]                         rd_addr,
   input  logic [bthq_pkg::INDEX_W-1:0]              req_box_index,
   input  logic signed [bthq_pkg::DATA_W-1:0]        req_point_x,
   input  logic signed [bthq_pkg::DATA_W-1:0]        req_point_y,
   input  logic signed [bthq_pkg::DATA_W-1:0]        req_corner_x,
   input  logic signed [bthq_pkg::DATA_W-1:0]        req_corner_y,
   input  logic signed [bthq_pkg::DATA_W-1:0]        req_extent_x,
   input  logic signed [bthq_pkg::DATA_W-1:0]        req_extent_y,
   input  logic signed [bthq_pkg::DATA_W-1:0]        req_box_top,
   input  logic                                      csr_write,
   input  logic [bthq_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [bthq_pkg::DATA_W-1:0]               csr_wdata,
   output logic                                      rsp_valid,
   output logic signed [bthq_pkg::DATA_W-1:0]        rsp_terrain_height
);
   import bthq_pkg::*;

   localparam int CNT_W = $clog2(MAX_BOXES + 1);
   localparam int CMP_W = ((CNT_W > INDEX_W) ? CNT_W : INDEX_W) + 1;

   logic signed [DATA_W-1:0] x_lower_ff;
   logic signed [DATA_W-1:0] x_upper_ff;
   logic signed [DATA_W-1:0] def_height_ff;
   logic [COUNT_W-1:0]       box_count_ff;

   logic signed [DATA_W-1:0] px_ff;
   logic signed [DATA_W-1:0] py_ff;
   logic                     oob_ff;
   logic signed [DATA_W-1:0] best_ff;

   logic                     rd_valid_ff;
   logic                     cmp_valid_ff;
   logic                     hit_ff, hit_in;
   logic signed [DATA_W-1:0] top_ff;

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_height_ff;

   logic                     wr_en;
   box_entry_type            wr_entry;
   logic [ENTRY_W-1:0]       rd_data;
   box_entry_type            rd_entry;

   logic signed [DATA_W:0]   lo_x, hi_x, lo_y, hi_y, p_x, p_y;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         x_lower_ff    <= '0;
         x_upper_ff    <= '0;
         def_height_ff <= '0;
         box_count_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_X_LOWER:   x_lower_ff    <= csr_wdata;
            CSR_X_UPPER:   x_upper_ff    <= csr_wdata;
            CSR_DEF_HT:    def_height_ff <= csr_wdata;
            CSR_BOX_COUNT: box_count_ff  <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Box table: drop loads to slots beyond the table
   assign wr_en = cmd.load && (CMP_W'(req_box_index) < CMP_W'(MAX_BOXES));
   assign wr_entry.corner_x = req_corner_x;
   assign wr_entry.corner_y = req_corner_y;
   assign wr_entry.extent_x = req_extent_x;
   assign wr_entry.extent_y = req_extent_y;
   assign wr_entry.top      = req_box_top;

   bthq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_BOXES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req_box_index)),
      .wr_data (wr_entry),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_entry = rd_data;

   // Strict containment on both axes, upper edge formed exactly in 25 bits
   assign lo_x   = {rd_entry.corner_x[DATA_W-1], rd_entry.corner_x};
   assign lo_y   = {rd_entry.corner_y[DATA_W-1], rd_entry.corner_y};
   assign hi_x   = lo_x + {rd_entry.extent_x[DATA_W-1], rd_entry.extent_x};
   assign hi_y   = lo_y + {rd_entry.extent_y[DATA_W-1], rd_entry.extent_y};
   assign p_x    = {px_ff[DATA_W-1], px_ff};
   assign p_y    = {py_ff[DATA_W-1], py_ff};
   assign hit_in = (lo_x < p_x) && (p_x < hi_x) && (lo_y < p_y) && (p_y < hi_y);

   // Scan pipeline: read, compare, update maximum (ties keep the earlier one)
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         cmp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= cmd.rd_en;
         cmp_valid_ff <= rd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      top_ff <= rd_entry.top;
      if (cmd.capture) begin
         px_ff   <= req_point_x;
         py_ff   <= req_point_y;
         oob_ff  <= status.out_of_range;
         best_ff <= def_height_ff;
      end else if (cmp_valid_ff && hit_ff && (top_ff > best_ff)) begin
         best_ff <= top_ff;
      end
   end

   // Result beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_height_ff <= oob_ff ? '0 : best_ff;
      end
   end

   assign status.out_of_range = (req_point_x < x_lower_ff) || (req_point_x > x_upper_ff);
   assign status.pipe_busy    = rd_valid_ff || cmp_valid_ff;
   assign status.box_count    = box_count_ff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_terrain_height = rsp_height_ff;

endmodule

FILE: design/box_terrain_height_query.sv
// ----------------------------------------------------------------------------
// Box terrain height query
// Holds a table of axis-aligned boxes and answers the highest box top over a
// point, or the default height, or zero off the terrain.
//
//   channel   handshake            payload
//   request   start / busy         req_op, req_box_index, req_point_*,
//                                  req_corner_*, req_extent_*, req_box_top
//   result    rsp_valid (strobe)   rsp_terrain_height
//   config    csr_valid / csr_ready csr_index, csr_wdata
//
// A load beat writes its table slot in the cycle it is taken; busy stays low.
// A query scans the configured boxes and then strobes its result; off the
// terrain or with no boxes it skips the scan. The scan reads one entry a cycle
// from the single box RAM read port, then drains the read and compare registers.
// busy is high from the cycle after a query is taken until the emit cycle.
// Reset is synchronous; the table is not cleared. The receiver cannot stall.
// ----------------------------------------------------------------------------
module box_terrain_height_query #(
   parameter int MAX_BOXES = bthq_pkg::MAX_BOXES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_op,
   input  logic [bthq_pkg::INDEX_W-1:0]        req_box_index,
   input  logic signed [bthq_pkg::DATA_W-1:0]  req_point_x,
   input  logic signed [bthq_pkg::DATA_W-1:0]  req_point_y,
   input  logic signed [bthq_pkg::DATA_W-1:0]  req_corner_x,
   input  logic signed [bthq_pkg::DATA_W-1:0]  req_corner_y,
   input  logic signed [bthq_pkg::DATA_W-1:0]  req_extent_x,
   input  logic signed [bthq_pkg::DATA_W-1:0]  req_extent_y,
   input  logic signed [bthq_pkg::DATA_W-1:0]  req_box_top,
   output logic                                rsp_valid,
   output logic signed [bthq_pkg::DATA_W-1:0]  rsp_terrain_height,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bthq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bthq_pkg::DATA_W-1:0]         csr_wdata
);
   import bthq_pkg::*;

   localparam int ADDR_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

   ctrl_cmd_type      cmd;
   dp_status_type     status;
   logic [ADDR_W-1:0] rd_addr;

   // Registers take a beat in any cycle
   assign csr_ready = 1'b1;

   bthq_ctrl #(
      .MAX_BOXES (MAX_BOXES)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_op  (req_op),
      .busy    (busy),
      .status  (status),
      .cmd     (cmd),
      .rd_addr (rd_addr)
   );

   bthq_dp #(
      .MAX_BOXES (MAX_BOXES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .rd_addr            (rd_addr),
      .req_box_index      (req_box_index),
      .req_point_x        (req_point_x),
      .req_point_y        (req_point_y),
      .req_corner_x       (req_corner_x),
      .req_corner_y       (req_corner_y),
      .req_extent_x       (req_extent_x),
      .req_extent_y       (req_extent_y),
      .req_box_top        (req_box_top),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_terrain_height (rsp_terrain_height)
   );

endmodule
